// File: src/nls_pkg.sv
// ----------------------------------------------------------------------------
// nls_pkg
// Shared widths, character codes and digit helpers for the numeric literal
// scanner.
// ----------------------------------------------------------------------------
package nls_pkg;

   localparam int unsigned CHAR_W  = 16;
   localparam int unsigned CLASS_W = 3;
   localparam int unsigned WORD_W  = 16;
   localparam int unsigned IDX_W   = 6;

   localparam logic [CHAR_W-1:0] CH_SPACE  = 16'h0020;
   localparam logic [CHAR_W-1:0] CH_DOLLAR = 16'h0024;
   localparam logic [CHAR_W-1:0] CH_STAR   = 16'h002A;
   localparam logic [CHAR_W-1:0] CH_COMMA  = 16'h002C;
   localparam logic [CHAR_W-1:0] CH_DOT    = 16'h002E;
   localparam logic [CHAR_W-1:0] CH_SLASH  = 16'h002F;
   localparam logic [CHAR_W-1:0] CH_0      = 16'h0030;
   localparam logic [CHAR_W-1:0] CH_1      = 16'h0031;
   localparam logic [CHAR_W-1:0] CH_7      = 16'h0037;
   localparam logic [CHAR_W-1:0] CH_9      = 16'h0039;
   localparam logic [CHAR_W-1:0] CH_SEMI   = 16'h003B;
   localparam logic [CHAR_W-1:0] CH_A      = 16'h0041;
   localparam logic [CHAR_W-1:0] CH_B      = 16'h0042;
   localparam logic [CHAR_W-1:0] CH_D      = 16'h0044;
   localparam logic [CHAR_W-1:0] CH_F      = 16'h0046;
   localparam logic [CHAR_W-1:0] CH_H      = 16'h0048;
   localparam logic [CHAR_W-1:0] CH_O      = 16'h004F;
   localparam logic [CHAR_W-1:0] CH_R      = 16'h0052;
   localparam logic [CHAR_W-1:0] CH_X      = 16'h0058;
   localparam logic [CHAR_W-1:0] CH_Z      = 16'h005A;

   localparam logic [CLASS_W-1:0] CLS_DIGIT  = 3'd0;
   localparam logic [CLASS_W-1:0] CLS_LETTER = 3'd1;
   localparam logic [CLASS_W-1:0] CLS_EOL    = 3'd3;

   localparam logic [WORD_W-1:0] RAD50_MULT0 = 16'd1600;
   localparam logic [WORD_W-1:0] RAD50_MULT1 = 16'd40;

   // result flag positions in rsp_tuser
   localparam int unsigned FLG_CONSUMED = 0;
   localparam int unsigned FLG_BAD_NUM  = 1;
   localparam int unsigned FLG_OVERFLOW = 2;
   localparam int unsigned FLG_BAD_PFX  = 3;
   localparam int unsigned FLG_OK       = 4;
   localparam int unsigned FLG_W        = 5;

   typedef enum logic [1:0] {
      RADIX_BIN,
      RADIX_OCT,
      RADIX_DEC,
      RADIX_HEX
   } radix_type;

   // acc * radix + digit; bit WORD_W flags a carry out of the word
   function automatic logic [WORD_W:0] mac_step(input logic [WORD_W-1:0] acc,
                                               input radix_type radix,
                                               input logic [3:0] digit);
      logic [WORD_W+3:0] t;
      logic [WORD_W+3:0] a;
      a = {4'b0000, acc};
      case (radix)
         RADIX_BIN: t = (a << 1) + {16'h0000, digit};
         RADIX_OCT: t = (a << 3) + {16'h0000, digit};
         RADIX_DEC: t = (a << 3) + (a << 1) + {16'h0000, digit};
         RADIX_HEX: t = (a << 4) + {16'h0000, digit};
         default:   t = a;
      endcase
      return {|t[WORD_W+3:WORD_W], t[WORD_W-1:0]};
   endfunction

   function automatic logic [IDX_W-1:0] rad50_index(input logic [CHAR_W-1:0] c);
      logic [IDX_W-1:0] idx;
      idx = '0;
      if (c >= CH_A && c <= CH_Z) begin
         idx = IDX_W'(c - 16'h0040);
      end else if (c == CH_DOLLAR) begin
         idx = 6'd27;
      end else if (c == CH_DOT) begin
         idx = 6'd28;
      end else if (c >= CH_0 && c <= CH_9) begin
         idx = IDX_W'(c - CH_0 + 16'd30);
      end
      return idx;
   endfunction

endpackage

// File: src/numeric_literal_scanner.sv
// ----------------------------------------------------------------------------
// numeric_literal_scanner
// Folds a stream of characters into 16-bit assembler numeric literals
// (octal, decimal, hex, binary and three-character RADIX-50 words).
// ----------------------------------------------------------------------------
//  channel | dir | tdata                              | tuser
//  req_    | in  | [15:0] char_code [31:16] lookahead | [0] start [1] caret [4:2] class
//  rsp_    | out | [15:0] value                       | [0] consumed [1] bad_number
//          |     |                                    | [2] overflow [3] bad_prefix [4] ok
//
//  One character per cycle while rsp_ is not stalled; each transfer passes an input
//  register and then, with its state update, the result register on its way to rsp_.
//  Characters that end no literal leave no result.
//  Reset is synchronous and clears the scan state and both valid flags.
//  A stalled result holds the input register; while both are full, req_tready follows rsp_tready.
// ----------------------------------------------------------------------------
module numeric_literal_scanner (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // char_code, lookahead_code
   input  logic [4:0]  req_tuser,   // start_req, caret_mode, char_class
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // value
   output logic [4:0]  rsp_tuser    // consumed, bad_number, word_overflow, bad_prefix, ok
);
   import nls_pkg::*;

   typedef enum logic [3:0] {
      PH_IDLE, PH_PLAIN, PH_SKIPX, PH_SKIPD, PH_SKIPB,
      PH_HEX, PH_DEC, PH_OCT, PH_BIN, PH_RAD
   } phase_type;

   logic                 in_valid_ff;
   logic                 start_ff, caret_ff;
   logic [CHAR_W-1:0]    code_ff, la_ff;
   logic [CLASS_W-1:0]   class_ff;

   phase_type            phase_ff, phase_in;
   logic [WORD_W-1:0]    main_ff, main_in, dec_ff, dec_in;
   logic                 main_over_ff, main_over_in, dec_over_ff, dec_over_in;
   logic                 high_ff, high_in, seen_ff, seen_in;
   logic [1:0]           count_ff, count_in;

   logic                 out_valid_ff, out_valid_in;
   logic [WORD_W-1:0]    out_value_ff;
   logic [FLG_W-1:0]     out_flags_ff;

   logic                 advance;
   logic                 emit;
   logic [WORD_W-1:0]    e_value;
   logic                 e_cons, e_bad, e_ovf, e_pfx;

   phase_type            ph;
   logic [WORD_W-1:0]    w_main, w_dec;
   logic                 w_main_over, w_dec_over, w_high, w_seen;
   logic [1:0]           w_count;
   logic                 is_dec;
   logic [WORD_W:0]      mac_main, mac_dec;
   logic [3:0]           digit;
   logic [CHAR_W-1:0]    top;
   radix_type            radix;
   logic [WORD_W-1:0]    r50_term;
   logic [IDX_W-1:0]     r50_idx;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_value_ff;
   assign rsp_tuser  = out_flags_ff;

   always_comb begin
      // a start drops any literal in progress
      ph          = start_ff ? PH_IDLE : phase_ff;
      w_main      = start_ff ? '0 : main_ff;
      w_dec       = start_ff ? '0 : dec_ff;
      w_main_over = start_ff ? 1'b0 : main_over_ff;
      w_dec_over  = start_ff ? 1'b0 : dec_over_ff;
      w_high      = start_ff ? 1'b0 : high_ff;
      w_seen      = start_ff ? 1'b0 : seen_ff;
      w_count     = start_ff ? 2'd0 : count_ff;

      is_dec   = code_ff >= CH_0 && code_ff <= CH_9;
      digit    = code_ff[3:0];
      radix    = RADIX_OCT;
      top      = CH_7;
      mac_main = '0;
      mac_dec  = '0;
      r50_idx  = rad50_index(code_ff);
      case (w_count)
         2'd0:    r50_term = 16'(r50_idx) * RAD50_MULT0;
         2'd1:    r50_term = 16'(r50_idx) * RAD50_MULT1;
         default: r50_term = 16'(r50_idx);
      endcase

      phase_in     = ph;
      main_in      = w_main;
      dec_in       = w_dec;
      main_over_in = w_main_over;
      dec_over_in  = w_dec_over;
      high_in      = w_high;
      seen_in      = w_seen;
      count_in     = w_count;
      emit         = 1'b0;
      e_value      = '0;
      e_cons       = 1'b0;
      e_bad        = 1'b0;
      e_ovf        = 1'b0;
      e_pfx        = 1'b0;

      if (start_ff && caret_ff) begin
         if (code_ff == CH_X || code_ff == CH_H) begin
            phase_in = PH_HEX;
         end else if (code_ff == CH_D) begin
            phase_in = PH_DEC;
         end else if (code_ff == CH_O) begin
            phase_in = PH_OCT;
         end else if (code_ff == CH_B) begin
            phase_in = PH_BIN;
         end else if (code_ff == CH_R) begin
            phase_in = PH_RAD;
         end else begin
            emit  = 1'b1;
            e_pfx = 1'b1;
         end
      end else if (start_ff && code_ff == CH_0 && la_ff == CH_X) begin
         phase_in = PH_SKIPX;
      end else if (start_ff && code_ff == CH_0 && la_ff == CH_D) begin
         phase_in = PH_SKIPD;
      end else if (start_ff && code_ff == CH_0 && la_ff == CH_B) begin
         phase_in = PH_SKIPB;
      end else if (start_ff) begin
         ph       = PH_PLAIN;
         phase_in = PH_PLAIN;
      end

      if (!(start_ff && caret_ff)) begin
         case (ph)
            PH_PLAIN: begin
               if (class_ff == CLS_DIGIT) begin
                  if (!is_dec) begin
                     emit  = 1'b1;
                     e_bad = 1'b1;
                  end else begin
                     mac_main     = mac_step(w_main, RADIX_OCT, {1'b0, digit[2:0]});
                     mac_dec      = mac_step(w_dec, RADIX_DEC, digit);
                     main_in      = mac_main[WORD_W-1:0];
                     main_over_in = w_main_over | mac_main[WORD_W];
                     dec_in       = mac_dec[WORD_W-1:0];
                     dec_over_in  = w_dec_over | mac_dec[WORD_W];
                     high_in      = w_high | digit[3];
                     seen_in      = 1'b1;
                  end
               end else if (code_ff == CH_DOT) begin
                  emit   = 1'b1;
                  e_cons = 1'b1;
                  if (!w_seen) begin
                     e_bad = 1'b1;
                  end else begin
                     e_value = w_dec;
                     e_ovf   = w_dec_over;
                  end
               end else if (w_high || !w_seen) begin
                  emit  = 1'b1;
                  e_bad = 1'b1;
               end else begin
                  emit    = 1'b1;
                  e_value = w_main;
                  e_ovf   = w_main_over;
               end
            end
            PH_SKIPX: phase_in = PH_HEX;
            PH_SKIPD: phase_in = PH_DEC;
            PH_SKIPB: phase_in = PH_BIN;
            PH_HEX: begin
               if (class_ff == CLS_DIGIT && is_dec) begin
                  radix = RADIX_HEX;
               end else if (class_ff == CLS_LETTER && code_ff >= CH_A && code_ff <= CH_F) begin
                  radix = RADIX_HEX;
                  digit = code_ff[3:0] + 4'd9;
               end else begin
                  emit    = 1'b1;
                  e_value = w_main;
                  e_ovf   = w_main_over;
                  e_bad   = class_ff == CLS_DIGIT || class_ff == CLS_LETTER;
               end
               if (!emit) begin
                  mac_main     = mac_step(w_main, radix, digit);
                  main_in      = mac_main[WORD_W-1:0];
                  main_over_in = w_main_over | mac_main[WORD_W];
               end
            end
            PH_DEC, PH_OCT, PH_BIN: begin
               case (ph)
                  PH_DEC:  begin radix = RADIX_DEC; top = CH_9; end
                  PH_BIN:  begin radix = RADIX_BIN; top = CH_1; end
                  default: begin radix = RADIX_OCT; top = CH_7; end
               endcase
               if (class_ff != CLS_DIGIT || code_ff < CH_0 || code_ff > top) begin
                  emit    = 1'b1;
                  e_value = w_main;
                  e_ovf   = w_main_over;
                  e_bad   = class_ff == CLS_DIGIT;
               end else begin
                  mac_main     = mac_step(w_main, radix, digit);
                  main_in      = mac_main[WORD_W-1:0];
                  main_over_in = w_main_over | mac_main[WORD_W];
               end
            end
            PH_RAD: begin
               if (w_count != 2'd0 &&
                   (code_ff == CH_COMMA || code_ff == CH_SEMI || class_ff == CLS_EOL ||
                    (code_ff == CH_SLASH && (la_ff == CH_SLASH || la_ff == CH_STAR)))) begin
                  emit    = 1'b1;
                  e_value = w_main;
               end else begin
                  main_in  = w_main + r50_term;
                  count_in = w_count + 2'd1;
                  if (w_count == 2'd2) begin
                     emit    = 1'b1;
                     e_cons  = 1'b1;
                     e_value = w_main + r50_term;
                  end
               end
            end
            PH_IDLE: ;
            default: phase_in = PH_IDLE;
         endcase
      end

      if (emit) begin
         phase_in = PH_IDLE;
      end
      if (!start_ff && ph == PH_IDLE) begin
         phase_in = PH_IDLE;
      end

      out_valid_in = (advance && emit) || (out_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         start_ff <= req_tuser[0];
         caret_ff <= req_tuser[1];
         class_ff <= req_tuser[4:2];
         code_ff  <= req_tdata[15:0];
         la_ff    <= req_tdata[31:16];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         phase_ff     <= PH_IDLE;
         main_ff      <= '0;
         dec_ff       <= '0;
         main_over_ff <= 1'b0;
         dec_over_ff  <= 1'b0;
         high_ff      <= 1'b0;
         seen_ff      <= 1'b0;
         count_ff     <= 2'd0;
         out_value_ff <= '0;
         out_flags_ff <= '0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         out_valid_ff <= out_valid_in;
         if (advance) begin
            phase_ff     <= phase_in;
            main_ff      <= main_in;
            dec_ff       <= dec_in;
            main_over_ff <= main_over_in;
            dec_over_ff  <= dec_over_in;
            high_ff      <= high_in;
            seen_ff      <= seen_in;
            count_ff     <= count_in;
            if (emit) begin
               out_value_ff               <= e_value;
               out_flags_ff[FLG_CONSUMED] <= e_cons;
               out_flags_ff[FLG_BAD_NUM]  <= e_bad;
               out_flags_ff[FLG_OVERFLOW] <= e_ovf;
               out_flags_ff[FLG_BAD_PFX]  <= e_pfx;
               out_flags_ff[FLG_OK]       <= !(e_bad || e_ovf || e_pfx);
            end
         end
      end
   end

endmodule

// File: src/nls_checker.sv
// ----------------------------------------------------------------------------
// nls_checker
// Port-level checks on the numeric literal scanner result channel.
// ----------------------------------------------------------------------------
module nls_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic [4:0]  rsp_tuser
);
   import nls_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   a_ok_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser[FLG_OK] ==
         !(rsp_tuser[FLG_BAD_NUM] || rsp_tuser[FLG_OVERFLOW] || rsp_tuser[FLG_BAD_PFX]))
      else $error("ok flag disagrees with error flags");

   a_bad_prefix: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[FLG_BAD_PFX] |->
         rsp_tdata == 16'h0000 && !rsp_tuser[FLG_CONSUMED] &&
         !rsp_tuser[FLG_BAD_NUM] && !rsp_tuser[FLG_OVERFLOW])
      else $error("bad prefix result not clean");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind numeric_literal_scanner nls_checker u_nls_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// File: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for numeric_literal_scanner. Character streams (plain
// and caret literals, broken sequences, raw noise) are sent over req_ with
// random gaps; rsp_ is stalled at random. Every req_ transfer is folded into
// a local scanner model and each rsp_ transfer is checked against the oldest
// literal it predicted.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import nls_pkg::*;

   localparam int unsigned QUIET_LIMIT = 1000;
   localparam int unsigned DRAIN_CYCLES = 16;
   localparam int unsigned RANDOM_CHARS = 1000;

   localparam logic [CLASS_W-1:0] CLS_SPACE = 3'd2;
   localparam logic [CLASS_W-1:0] CLS_OTHER = 3'd4;
   localparam logic [CHAR_W-1:0]  CH_LF     = 16'h000A;

   localparam string RAD50_CHARS = " ABCDEFGHIJKLMNOPQRSTUVWXYZ$. 0123456789";
   localparam string RAD50_POOL  = " ABCDEFGHIJKLMNOPQRSTUVWXYZ$.0123456789%?";
   localparam string NOISE_POOL  = "0123456789ABCDEFGXZ .,;/*\n$";
   localparam string LA_POOL     = "0XDB/*, A";

   typedef enum logic [3:0] {
      SC_IDLE,
      SC_PLAIN,
      SC_SKIP_HEX,
      SC_SKIP_DEC,
      SC_SKIP_BIN,
      SC_HEX,
      SC_DEC,
      SC_OCT,
      SC_BIN,
      SC_RAD50
   } scan_phase_type;

   typedef struct packed {
      logic [WORD_W-1:0] value;
      logic              consumed;
      logic              bad_number;
      logic              word_overflow;
      logic              bad_prefix;
      logic              ok;
   } literal_type;

   typedef struct {
      logic               start;
      logic               caret;
      logic [CHAR_W-1:0]  code;
      logic [CLASS_W-1:0] cls;
      logic [CHAR_W-1:0]  la;
      logic               hold;
   } char_xfer_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // char_code, lookahead_code
   logic [4:0]  req_tuser = '0;   // start_req, caret_mode, char_class
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;        // value
   logic [4:0]  rsp_tuser;        // consumed, bad_number, word_overflow, bad_prefix, ok

   numeric_literal_scanner dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   char_xfer_type pending[$];
   byte unsigned  draft[$];
   literal_type   literal_q[$];
   string         endings[11] = '{" ", "\n", ",", ";", ".", "//", "/*", "/A", "G", "9", "$"};

   scan_phase_type    phase = SC_IDLE;
   logic [WORD_W-1:0] main_acc = '0;
   logic [WORD_W-1:0] dec_acc = '0;
   bit                main_ovf;
   bit                dec_ovf;
   bit                high_digit;
   bit                any_digit;
   logic [1:0]        rad_count = '0;

   int unsigned faults;
   int unsigned results_open;
   int unsigned send_wait;
   int unsigned send_run;
   bit          send_steady;
   int unsigned recv_wait;
   int unsigned recv_run;
   bit          recv_steady;
   int unsigned quiet;

   initial forever #6 clock = ~clock;

   function automatic int unsigned draw_wait(inout int unsigned run_left, inout bit steady);
      if (run_left == 0) begin
         run_left = $urandom_range(10, 60);
         steady = ~steady;
      end else begin
         run_left--;
      end
      return steady ? 0 : $urandom_range(0, 15);
   endfunction

   function automatic logic [CLASS_W-1:0] class_of(byte unsigned ch);
      logic [CHAR_W-1:0] c;
      c = {8'h00, ch};
      if (c >= CH_0 && c <= CH_9) return CLS_DIGIT;
      if (c >= CH_A && c <= CH_Z) return CLS_LETTER;
      if (c == CH_SPACE) return CLS_SPACE;
      if (c == CH_LF) return CLS_EOL;
      return CLS_OTHER;
   endfunction

   task automatic note_fault(input string msg);
      faults++;
      if (faults <= 10) $display("%t %s", $realtime, msg);
   endtask

   // ---- scanner model ------------------------------------------------------

   task automatic close_literal(input logic [WORD_W-1:0] v, input bit cons, input bit bad,
                                input bit ovf, input bit pfx);
      literal_type r;
      r.value = v;
      r.consumed = cons;
      r.bad_number = bad;
      r.word_overflow = ovf;
      r.bad_prefix = pfx;
      r.ok = !(bad || ovf || pfx);
      literal_q = {literal_q, r};
      phase = SC_IDLE;
   endtask

   task automatic fold(inout logic [WORD_W-1:0] acc, inout bit over, input int unsigned radix,
                       input int unsigned d);
      int unsigned t;
      t = acc * radix + d;
      if (t > 65535) over = 1'b1;
      acc = t[WORD_W-1:0];
   endtask

   task automatic scan_plain(input logic [CHAR_W-1:0] c, input logic [CLASS_W-1:0] cls);
      int unsigned d;
      if (cls == CLS_DIGIT) begin
         if (c < CH_0 || c > CH_9) begin
            close_literal('0, 1'b0, 1'b1, 1'b0, 1'b0);
         end else begin
            d = c - CH_0;
            fold(main_acc, main_ovf, 8, d & 7);
            fold(dec_acc, dec_ovf, 10, d);
            if (d >= 8) high_digit = 1'b1;
            any_digit = 1'b1;
         end
      end else if (c == CH_DOT) begin
         if (!any_digit) close_literal('0, 1'b1, 1'b1, 1'b0, 1'b0);
         else close_literal(dec_acc, 1'b1, 1'b0, dec_ovf, 1'b0);
      end else if (high_digit || !any_digit) begin
         close_literal('0, 1'b0, 1'b1, 1'b0, 1'b0);
      end else begin
         close_literal(main_acc, 1'b0, 1'b0, main_ovf, 1'b0);
      end
   endtask

   task automatic scan_digits(input logic [CHAR_W-1:0] c, input logic [CLASS_W-1:0] cls);
      int unsigned d;
      int unsigned radix;
      logic [CHAR_W-1:0] top;
      if (phase == SC_HEX) begin
         radix = 16;
         if (cls == CLS_DIGIT && c >= CH_0 && c <= CH_9) begin
            d = c - CH_0;
         end else if (cls == CLS_LETTER && c >= CH_A && c <= CH_F) begin
            d = c - CH_A + 10;
         end else begin
            close_literal(main_acc, 1'b0, cls == CLS_DIGIT || cls == CLS_LETTER, main_ovf,
                          1'b0);
            return;
         end
      end else begin
         radix = (phase == SC_DEC) ? 10 : (phase == SC_OCT) ? 8 : 2;
         top = (phase == SC_DEC) ? CH_9 : (phase == SC_OCT) ? CH_7 : CH_1;
         if (cls != CLS_DIGIT) begin
            close_literal(main_acc, 1'b0, 1'b0, main_ovf, 1'b0);
            return;
         end
         if (c < CH_0 || c > top) begin
            close_literal(main_acc, 1'b0, 1'b1, main_ovf, 1'b0);
            return;
         end
         d = c - CH_0;
      end
      fold(main_acc, main_ovf, radix, d);
   endtask

   task automatic scan_rad50(input logic [CHAR_W-1:0] c, input logic [CLASS_W-1:0] cls,
                             input logic [CHAR_W-1:0] la);
      int unsigned idx;
      int unsigned k;
      int unsigned mult;
      if (rad_count != 0 && (c == CH_COMMA || c == CH_SEMI || cls == CLS_EOL ||
                             (c == CH_SLASH && (la == CH_SLASH || la == CH_STAR)))) begin
         close_literal(main_acc, 1'b0, 1'b0, 1'b0, 1'b0);
         return;
      end
      idx = 0;
      for (k = 40; k > 0; k--) begin
         if (c == {8'h00, RAD50_CHARS[k-1]}) idx = k - 1;
      end
      mult = (rad_count == 0) ? RAD50_MULT0 : (rad_count == 1) ? RAD50_MULT1 : 1;
      main_acc = WORD_W'(main_acc + idx * mult);
      rad_count++;
      if (rad_count == 3) close_literal(main_acc, 1'b1, 1'b0, 1'b0, 1'b0);
   endtask

   task automatic scan_char(input logic start, input logic caret, input logic [CHAR_W-1:0] c,
                            input logic [CLASS_W-1:0] cls, input logic [CHAR_W-1:0] la);
      if (start) begin
         main_acc = '0;
         dec_acc = '0;
         main_ovf = 1'b0;
         dec_ovf = 1'b0;
         high_digit = 1'b0;
         any_digit = 1'b0;
         rad_count = '0;
         if (caret) begin
            case (c)
               CH_X, CH_H: phase = SC_HEX;
               CH_D:       phase = SC_DEC;
               CH_O:       phase = SC_OCT;
               CH_B:       phase = SC_BIN;
               CH_R:       phase = SC_RAD50;
               default:    close_literal('0, 1'b0, 1'b0, 1'b0, 1'b1);
            endcase
         end else if (c == CH_0 && la == CH_X) begin
            phase = SC_SKIP_HEX;
         end else if (c == CH_0 && la == CH_D) begin
            phase = SC_SKIP_DEC;
         end else if (c == CH_0 && la == CH_B) begin
            phase = SC_SKIP_BIN;
         end else begin
            phase = SC_PLAIN;
            scan_plain(c, cls);
         end
      end else begin
         case (phase)
            SC_PLAIN:                        scan_plain(c, cls);
            SC_SKIP_HEX:                     phase = SC_HEX;
            SC_SKIP_DEC:                     phase = SC_DEC;
            SC_SKIP_BIN:                     phase = SC_BIN;
            SC_HEX, SC_DEC, SC_OCT, SC_BIN:  scan_digits(c, cls);
            SC_RAD50:                        scan_rad50(c, cls, la);
            default:                         phase = SC_IDLE;
         endcase
      end
   endtask

   // ---- stimulus -----------------------------------------------------------

   task automatic put_text(input string s);
      int unsigned i;
      for (i = 0; i < s.len(); i++) draft = {draft, s[i]};
   endtask

   task automatic put_chars(input string alpha, input int unsigned n);
      int unsigned i;
      for (i = 0; i < n; i++) draft = {draft, alpha[$urandom_range(0, alpha.len() - 1)]};
   endtask

   task automatic ship_draft(input bit caret, input bit hold, input bit messy);
      char_xfer_type x;
      int unsigned i;
      for (i = 0; i < draft.size(); i++) begin
         x.start = (i == 0);
         x.caret = (i == 0) ? caret : 1'($urandom_range(0, 1));
         x.code = {8'h00, draft[i]};
         x.cls = class_of(draft[i]);
         if (i + 1 < draft.size()) x.la = {8'h00, draft[i+1]};
         else if (messy) x.la = {8'h00, LA_POOL[$urandom_range(0, LA_POOL.len() - 1)]};
         else x.la = CH_SPACE;
         x.hold = hold && (i == 0);
         if (messy && $urandom_range(0, 15) == 0) x.cls = CLASS_W'($urandom_range(0, 7));
         if (messy && $urandom_range(0, 31) == 0) x.code = CHAR_W'($urandom_range(0, 65535));
         pending = {pending, x};
      end
      draft.delete();
   endtask

   task automatic queue_noise(input int unsigned n);
      char_xfer_type x;
      int unsigned i;
      for (i = 0; i < n; i++) begin
         x.start = 1'($urandom_range(0, 1));
         x.caret = 1'($urandom_range(0, 1));
         x.code = CHAR_W'($urandom_range(0, 65535));
         x.cls = CLASS_W'($urandom_range(0, 7));
         x.la = CHAR_W'($urandom_range(0, 65535));
         x.hold = 1'b0;
         pending = {pending, x};
      end
   endtask

   task automatic queue_literal(input bit hold);
      int unsigned kind;
      bit wide;
      kind = $urandom_range(0, 11);
      wide = ($urandom_range(0, 4) == 0);
      case (kind)
         0, 1: put_chars(wide ? "0123456789" : "01234567", $urandom_range(1, 7));
         2: begin
            put_chars("0123456789", $urandom_range(0, 6));
            put_text(".");
         end
         3: begin
            put_text("0X");
            put_chars(wide ? "0123456789ABCDEFG" : "0123456789ABCDEF", $urandom_range(0, 5));
         end
         4: begin
            put_text("0D");
            put_chars(wide ? "0123456789A" : "0123456789", $urandom_range(0, 6));
         end
         5: begin
            put_text("0B");
            put_chars(wide ? "012" : "01", $urandom_range(0, 17));
         end
         6: begin
            put_text($urandom_range(0, 1) ? "X" : "H");
            put_chars(wide ? "0123456789ABCDEFG" : "0123456789ABCDEF", $urandom_range(0, 5));
         end
         7: begin
            put_text("D");
            put_chars(wide ? "0123456789A" : "0123456789", $urandom_range(0, 6));
         end
         8: begin
            put_text("O");
            put_chars(wide ? "0123456789" : "01234567", $urandom_range(0, 7));
         end
         9: begin
            put_text("B");
            put_chars(wide ? "012" : "01", $urandom_range(0, 17));
         end
         10: begin
            put_text("R");
            put_chars(RAD50_POOL, $urandom_range(1, 3));
         end
         default: put_chars("FQAZ@", 1);
      endcase
      if ($urandom_range(0, 5) != 0) put_text(endings[$urandom_range(0, 10)]);
      ship_draft(kind >= 6, hold, 1'b1);
   endtask

   initial begin : stimulus
      int unsigned target;
      int unsigned hold_mark;
      int unsigned pick;
      bit first;
      put_text("18 ");     ship_draft(1'b0, 1'b0, 1'b0);
      put_text("89.");     ship_draft(1'b0, 1'b0, 1'b0);
      put_text("0X ");     ship_draft(1'b0, 1'b0, 1'b0);
      put_text("0B2");     ship_draft(1'b0, 1'b0, 1'b0);
      put_text("F");       ship_draft(1'b1, 1'b0, 1'b0);
      put_text("H10000 "); ship_draft(1'b1, 1'b0, 1'b0);
      put_text("RA/*");    ship_draft(1'b1, 1'b0, 1'b0);
      put_text("R.9Z");    ship_draft(1'b1, 1'b0, 1'b0);
      target = pending.size() + RANDOM_CHARS;
      hold_mark = pending.size() + 300;
      first = 1'b1;
      while (pending.size() < target) begin
         pick = $urandom_range(0, 9);
         if (pick < 7) begin
            queue_literal(first || pending.size() >= hold_mark);
            if (!first && pending.size() >= hold_mark) hold_mark += 300;
            first = 1'b0;
         end else if (pick < 9) begin
            put_chars(NOISE_POOL, $urandom_range(1, 6));
            ship_draft(1'($urandom_range(0, 1)), 1'b0, 1'b1);
         end else begin
            queue_noise($urandom_range(1, 4));
         end
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
   end

   // ---- driver -------------------------------------------------------------

   always @(posedge clock) begin : drive
      int unsigned w;
      char_xfer_type x;
      if (reset) begin
         req_tvalid <= 1'b0;
         send_wait <= 0;
      end else if (!req_tvalid || req_tready) begin
         w = req_tvalid ? draw_wait(send_run, send_steady) : send_wait;
         if (w == 0 && pending.size() > 0 &&
             (!pending[0].hold || (!req_tvalid && results_open == 0))) begin
            x = pending.pop_front();
            req_tdata <= {x.la, x.code};
            req_tuser <= {x.cls, x.caret, x.start};
            req_tvalid <= 1'b1;
            send_wait <= 0;
         end else begin
            req_tvalid <= 1'b0;
            send_wait <= (w > 0) ? w - 1 : 0;
         end
      end
   end

   // ---- monitor ------------------------------------------------------------

   always @(posedge clock) begin : observe
      int unsigned s;
      literal_type got;
      literal_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_wait <= 0;
         results_open <= 0;
      end else begin
         s = recv_wait;
         if (rsp_tvalid && rsp_tready) begin
            got.value = rsp_tdata;
            got.consumed = rsp_tuser[FLG_CONSUMED];
            got.bad_number = rsp_tuser[FLG_BAD_NUM];
            got.word_overflow = rsp_tuser[FLG_OVERFLOW];
            got.bad_prefix = rsp_tuser[FLG_BAD_PFX];
            got.ok = rsp_tuser[FLG_OK];
            if (literal_q.size() == 0) begin
               note_fault($sformatf("unexpected result value=%h flags=%b", got.value, rsp_tuser));
            end else begin
               want = literal_q.pop_front();
               if (got !== want)
                  note_fault($sformatf(
                     "mismatch value %h/%h cons %b/%b bad %b/%b ovf %b/%b pfx %b/%b ok %b/%b",
                     want.value, got.value, want.consumed, got.consumed,
                     want.bad_number, got.bad_number, want.word_overflow, got.word_overflow,
                     want.bad_prefix, got.bad_prefix, want.ok, got.ok));
            end
            s = draw_wait(recv_run, recv_steady);
         end
         if (req_tvalid && req_tready)
            scan_char(req_tuser[0], req_tuser[1], req_tdata[15:0], req_tuser[4:2],
                      req_tdata[31:16]);
         results_open <= literal_q.size();
         if (s == 0) begin
            rsp_tready <= 1'b1;
            recv_wait <= 0;
         end else begin
            rsp_tready <= 1'b0;
            recv_wait <= s - 1;
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   initial begin : closing
      @(negedge reset);
      while (pending.size() > 0 || req_tvalid || results_open != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (literal_q.size() != 0)
         note_fault($sformatf("%0d results never arrived", literal_q.size()));
      if (faults == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
